FILE: rtl/pic_pkg.sv
// Shared widths and constants for the polynomial interpolation coefficient block.
`timescale 1ns / 1ps
`default_nettype none
package pic_pkg;
    localparam int SAMPLE_W = 32;
    localparam int COEF_W   = 64;
    localparam int DEG_W    = 3;
    localparam int CFG_W    = 4;
    // Wide accumulator for the scaled monomial coefficients (wraps modulo 2^128).
    localparam int POLY_W   = 128;
    // Holds (n-1)! for n up to thirteen.
    localparam int SCALE_W  = 32;
    // Divider retires this many quotient bits per cycle.
    localparam int DIV_STEP = 4;
    localparam int FRAC_SHIFT = 16;
endpackage
`default_nettype wire

FILE: rtl/pic_front.sv
// Front end: collects samples into a run and pushes each full run to the queue.
`timescale 1ns / 1ps
`default_nettype none
module pic_front
    import pic_pkg::*;
#(
    parameter int MAX_POINTS = 8,
    parameter int IDX_W = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [SAMPLE_W-1:0]            s_sample,
    input  wire logic                           cfg_wr_en,
    input  wire logic [CFG_W-1:0]               cfg_wr_data,
    output logic                                push,
    input  wire logic                           full,
    output logic [MAX_POINTS*SAMPLE_W+IDX_W-1:0] push_data
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic [CFG_W-1:0]    point_count_reg;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    n_eff;
    logic [SAMPLE_W-1:0] store_reg [MAX_POINTS];
    logic                accept;
    logic                run_done;

    // Effective run length: zero reads as one, large values clamp.
    always_comb begin
        if (point_count_reg == '0) begin
            n_eff = IDX_W'(1);
        end else if ({{IDX_W{1'b0}}, point_count_reg} > (IDX_W+CFG_W)'(MAX_POINTS)) begin
            n_eff = IDX_W'(MAX_POINTS);
        end else begin
            n_eff = IDX_W'(point_count_reg);
        end
    end

    assign s_ready  = !full;
    assign accept   = s_valid && s_ready;
    assign run_done = accept && ((cnt_reg + IDX_W'(1)) == n_eff);
    assign push     = run_done;

    // The word that completes a run goes straight into the pushed vector.
    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            if (AW'(i) == cnt_reg[AW-1:0]) begin
                push_data[i*SAMPLE_W +: SAMPLE_W] = s_sample;
            end else begin
                push_data[i*SAMPLE_W +: SAMPLE_W] = store_reg[i];
            end
        end
        push_data[MAX_POINTS*SAMPLE_W +: IDX_W] = n_eff;
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cfg_wr_en) begin
            cnt_next = '0;
        end else if (run_done) begin
            cnt_next = '0;
        end else if (accept) begin
            cnt_next = cnt_reg + IDX_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= CFG_W'(1);
            cnt_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                point_count_reg <= cfg_wr_data;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Sample store.
    always_ff @(posedge aclk) begin
        if (accept) begin
            store_reg[cnt_reg[AW-1:0]] <= s_sample;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/pic_fifo.sv
// Two-entry queue of complete sample runs between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module pic_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    output logic                  rd_valid,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg, rptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];

    // Pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (wr_en) begin
                wptr_reg <= !wptr_reg;
            end
            if (rd_en) begin
                rptr_reg <= !rptr_reg;
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 2'd1;
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/pic_back.sv
// Back end: forward differences, Newton expansion, then one shared divider run once per coefficient.
`timescale 1ns / 1ps
`default_nettype none
module pic_back
    import pic_pkg::*;
#(
    parameter int MAX_POINTS = 8,
    parameter int IDX_W = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            rd_valid,
    output logic                                 rd_en,
    input  wire logic [MAX_POINTS*SAMPLE_W+IDX_W-1:0] rd_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [COEF_W-1:0]             m_coefficient,
    output logic [DEG_W-1:0]                     m_degree,
    output logic                                 m_last
);
    localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DIFF_W = SAMPLE_W + MAX_POINTS - 1;
    localparam int PROD_W = DIFF_W + SCALE_W + 1;
    localparam int DCNT_W = $clog2(POLY_W / DIV_STEP);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIFF  = 3'd1;
    localparam logic [2:0] S_EXP   = 3'd2;
    localparam logic [2:0] S_DIVLD = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_RND   = 3'd5;
    localparam logic [2:0] S_SAT   = 3'd6;

    logic [2:0]               state_reg;
    logic [1:0]               phase_reg;
    logic [IDX_W-1:0]         n_reg, k_reg, j_reg;
    logic [IDX_W-1:0]         k_m1;
    logic signed [DIFF_W-1:0] diff_reg [MAX_POINTS];
    logic [POLY_W-1:0]        poly_reg [MAX_POINTS];
    logic [SCALE_W-1:0]       scale_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [POLY_W-1:0]        q_reg;
    logic [SCALE_W-1:0]       rem_reg;
    logic                     neg_reg;
    logic [DCNT_W-1:0]        dcnt_reg;
    logic                     m_valid_reg;
    logic [COEF_W-1:0]        coef_reg;
    logic [DEG_W-1:0]         deg_reg;
    logic                     last_reg;

    logic [POLY_W-1:0]        shifted;
    logic [POLY_W-1:0]        q_step;
    logic [SCALE_W-1:0]       rem_step;
    logic [COEF_W-1:0]        limit;
    logic [COEF_W-1:0]        sat_mag;
    logic                     out_free;

    assign k_m1     = k_reg - IDX_W'(1);
    assign shifted  = {poly_reg[j_reg[AW-1:0]][POLY_W-FRAC_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};
    assign out_free = !m_valid_reg || m_ready;
    assign rd_en    = (state_reg == S_IDLE) && rd_valid;

    // Several restoring division steps per cycle on the quotient shift register.
    always_comb begin
        logic [SCALE_W:0] trial;
        q_step   = q_reg;
        rem_step = rem_reg;
        for (int i = 0; i < DIV_STEP; i++) begin
            trial  = {rem_step, q_step[POLY_W-1]};
            q_step = {q_step[POLY_W-2:0], 1'b0};
            if (trial >= {1'b0, scale_reg}) begin
                trial     = trial - {1'b0, scale_reg};
                q_step[0] = 1'b1;
            end
            rem_step = trial[SCALE_W-1:0];
        end
    end

    // Saturation of the rounded magnitude.
    always_comb begin
        limit = neg_reg ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        if ((q_reg[POLY_W-1:COEF_W] != '0) || (q_reg[COEF_W-1:0] > limit)) begin
            sat_mag = limit;
        end else begin
            sat_mag = q_reg[COEF_W-1:0];
        end
    end

    // Control sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == S_SAT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (rd_valid) begin
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    if (k_reg >= n_reg) begin
                        state_reg <= S_EXP;
                        phase_reg <= 2'd0;
                    end
                end
                S_EXP: begin
                    if (k_reg == '0) begin
                        state_reg <= S_DIVLD;
                    end else if (phase_reg == 2'd2) begin
                        phase_reg <= 2'd0;
                    end else begin
                        phase_reg <= phase_reg + 2'd1;
                    end
                end
                S_DIVLD: state_reg <= S_DIV;
                S_DIV: begin
                    if (dcnt_reg == {DCNT_W{1'b1}}) begin
                        state_reg <= S_RND;
                    end
                end
                S_RND: state_reg <= S_SAT;
                S_SAT: begin
                    if (out_free) begin
                        state_reg <= (j_reg == n_reg - IDX_W'(1)) ? S_IDLE : S_DIVLD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                for (int i = 0; i < MAX_POINTS; i++) begin
                    diff_reg[i] <= DIFF_W'($signed(rd_data[i*SAMPLE_W +: SAMPLE_W]));
                end
                n_reg <= rd_data[MAX_POINTS*SAMPLE_W +: IDX_W];
                k_reg <= IDX_W'(1);
            end
            S_DIFF: begin
                if (k_reg < n_reg) begin
                    // One difference pass over all entries at or above k.
                    for (int i = 1; i < MAX_POINTS; i++) begin
                        if (IDX_W'(i) >= k_reg) begin
                            diff_reg[i] <= diff_reg[i] - diff_reg[i-1];
                        end
                    end
                    k_reg <= k_reg + IDX_W'(1);
                end else begin
                    for (int i = 1; i < MAX_POINTS; i++) begin
                        poly_reg[i] <= '0;
                    end
                    poly_reg[0] <= POLY_W'(diff_reg[k_m1[AW-1:0]]);
                    scale_reg   <= SCALE_W'(1);
                    k_reg       <= k_m1;
                end
            end
            S_EXP: begin
                if (k_reg == '0) begin
                    j_reg <= '0;
                end else begin
                    case (phase_reg)
                        2'd0: begin
                            // Multiply the Newton basis by (x - node).
                            scale_reg <= SCALE_W'(scale_reg * k_reg);
                            for (int i = 1; i < MAX_POINTS; i++) begin
                                poly_reg[i] <= poly_reg[i-1]
                                    - POLY_W'(poly_reg[i] * POLY_W'(k_m1));
                            end
                            poly_reg[0] <= POLY_W'(0) - POLY_W'(poly_reg[0] * POLY_W'(k_m1));
                        end
                        2'd1: begin
                            prod_reg <= PROD_W'(diff_reg[k_m1[AW-1:0]])
                                * PROD_W'($signed({1'b0, scale_reg}));
                        end
                        default: begin
                            poly_reg[0] <= poly_reg[0] + POLY_W'(prod_reg);
                            k_reg       <= k_m1;
                        end
                    endcase
                end
            end
            S_DIVLD: begin
                neg_reg  <= shifted[POLY_W-1];
                q_reg    <= shifted[POLY_W-1] ? (POLY_W'(0) - shifted) : shifted;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            S_DIV: begin
                q_reg    <= q_step;
                rem_reg  <= rem_step;
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
            S_RND: begin
                // Round half away from zero on the magnitude.
                if ({rem_reg, 1'b0} >= {1'b0, scale_reg}) begin
                    q_reg <= q_reg + POLY_W'(1);
                end
            end
            S_SAT: begin
                if (out_free) begin
                    coef_reg <= neg_reg ? (COEF_W'(0) - sat_mag) : sat_mag;
                    deg_reg  <= DEG_W'(j_reg);
                    last_reg <= (j_reg == n_reg - IDX_W'(1));
                    j_reg    <= j_reg + IDX_W'(1);
                end
            end
            default: begin
                j_reg <= j_reg;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_coefficient = $signed(coef_reg);
    assign m_degree      = deg_reg;
    assign m_last        = last_reg;
endmodule
`default_nettype wire

FILE: rtl/polynomial_interpolation_coeffs_core.sv
// Per run, the back end takes forward differences and a Newton expansion, then divides
// once per coefficient with the 4-bit-per-cycle divider (a 128-bit quotient divided by
// (n-1)!), then rounds and saturates; it takes no new run until the current run's last coefficient is out.
// Samples load one per cycle while the two-entry run queue has room.
// Reset (aresetn low, synchronous) sets point_count to 1 and empties the partial run.
`timescale 1ns / 1ps
`default_nettype none
module polynomial_interpolation_coeffs_core
    import pic_pkg::*;
#(
    parameter int MAX_POINTS = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample,
    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_W-1:0]           cfg_wr_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [COEF_W-1:0]        m_coefficient,
    output logic [DEG_W-1:0]                m_degree,
    output logic                            m_last
);
    localparam int IDX_W = $clog2(MAX_POINTS + 1);
    localparam int RUN_W = MAX_POINTS * SAMPLE_W + IDX_W;

    logic             push, full, rd_valid, rd_en;
    logic [RUN_W-1:0] push_data, rd_data;

    pic_front #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .push(push), .full(full), .push_data(push_data)
    );

    pic_fifo #(.WIDTH(RUN_W)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(push), .wr_data(push_data), .full(full),
        .rd_valid(rd_valid), .rd_en(rd_en), .rd_data(rd_data)
    );

    pic_back #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .rd_valid(rd_valid), .rd_en(rd_en), .rd_data(rd_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_coefficient(m_coefficient),
        .m_degree(m_degree), .m_last(m_last)
    );
endmodule
`default_nettype wire
